// ===== hdl/substring_first_match_assert.svh =====
// ----------------------------------------------------------------------------
// Substring first match assertion macros
// Concurrent check wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_FIRST_MATCH_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SFM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("substring_first_match: same-cycle check failed");

// next-cycle implication
`define SFM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("substring_first_match: next-cycle check failed");

`else

`define SFM_ASSERT_IMP(lbl, ante, cons)
`define SFM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/sfm_pkg.sv =====
// ----------------------------------------------------------------------------
// sfm_pkg
// Types and constants shared by the substring first match block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfm_pkg;

	localparam int PATTERN_MAX   = 16;
	localparam int POSITION_BITS = 16;

	// pattern bytes held by the two 64-bit pattern registers
	localparam int PATTERN_BYTES = 16;
	localparam int LEN_CAP       = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;
	localparam int LEN_W         = $clog2(LEN_CAP + 1);

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_LEN_W   = 5;
	localparam int INDEX_W     = 16;
	localparam int CMP_W       = (POSITION_BITS > INDEX_W) ? POSITION_BITS : INDEX_W;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_last;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] match_index;
		logic               overflow;
	} out_item_t;

	typedef struct packed {
		logic [PATTERN_BYTES*8-1:0] pattern;
		logic [CFG_LEN_W-1:0]       length;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/sfm_core.sv =====
// ----------------------------------------------------------------------------
// sfm_core
// Byte window, parallel pattern compare and per-text match state.
// ----------------------------------------------------------------------------
`default_nettype none

module sfm_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire sfm_pkg::in_item_t item,
	input  wire sfm_pkg::cfg_t     cfg,
	output sfm_pkg::out_item_t     result
);

	localparam int PB = sfm_pkg::POSITION_BITS;
	localparam int LC = sfm_pkg::LEN_CAP;
	localparam int LW = sfm_pkg::LEN_W;
	localparam int CW = sfm_pkg::CMP_W;
	localparam int IW = sfm_pkg::INDEX_W;

	logic [7:0]    win_q [LC];
	logic [7:0]    win_new [LC];
	logic [7:0]    pat [LC];
	logic [LC:0]   match_len;

	logic [PB-1:0] pos_q;
	logic          sat_q;
	logic          hit_q;
	logic [PB-1:0] first_q;

	logic [LW-1:0] len_eff;
	logic          sat_now;
	logic [PB-1:0] pos_next;
	logic [PB:0]   count;
	logic          eligible;
	logic          hit_new;
	logic          hit_now;
	logic [PB-1:0] first_calc;
	logic [PB-1:0] first_now;
	logic [CW-1:0] first_w;
	logic [IW-1:0] index_out;

	// window after this byte, newest at slot 0
	assign win_new[0] = item.text_byte;
	for (genvar j = 1; j < LC; j++) begin : g_shift
		assign win_new[j] = win_q[j-1];
	end

	for (genvar k = 0; k < LC; k++) begin : g_pat
		assign pat[k] = cfg.pattern[8*k +: 8];
	end

	// one equality vector per possible length; pattern byte 0 is the oldest byte
	assign match_len[0] = 1'b0;
	for (genvar gl = 1; gl <= LC; gl++) begin : g_len
		logic [gl-1:0] eq;
		for (genvar gk = 0; gk < gl; gk++) begin : g_byte
			assign eq[gk] = (win_new[gl-1-gk] == pat[gk]);
		end
		assign match_len[gl] = &eq;
	end

	always_comb begin
		if (cfg.length > sfm_pkg::CFG_LEN_W'(LC)) begin
			len_eff = LW'(LC);
		end else begin
			len_eff = LW'(cfg.length);
		end
	end

	always_comb begin
		sat_now    = sat_q || (pos_q == sfm_pkg::POS_MAX);
		pos_next   = (pos_q == sfm_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
		count      = {1'b0, pos_q} + 1'b1;
		eligible   = count >= (PB+1)'(len_eff);
		hit_new    = (len_eff != '0) && !hit_q && eligible && match_len[len_eff];
		hit_now    = hit_q || hit_new;
		first_calc = sat_now ? sfm_pkg::POS_MAX : PB'(count - (PB+1)'(len_eff));
		first_now  = hit_new ? first_calc : first_q;
		first_w    = CW'(first_now);
		index_out  = (first_w > CW'({IW{1'b1}})) ? {IW{1'b1}} : first_w[IW-1:0];
	end

	always_comb begin
		result.overflow = sat_now;
		if (len_eff == '0) begin
			result.found       = 1'b1;
			result.match_index = '0;
		end else if (hit_now) begin
			result.found       = 1'b1;
			result.match_index = index_out;
		end else begin
			result.found       = 1'b0;
			result.match_index = '0;
		end
	end

	// window is payload; stale bytes are masked by the eligibility check
	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sat_q   <= 1'b0;
			hit_q   <= 1'b0;
			first_q <= '0;
		end else if (advance) begin
			if (item.text_last) begin
				pos_q   <= '0;
				sat_q   <= 1'b0;
				hit_q   <= 1'b0;
				first_q <= '0;
			end else begin
				pos_q   <= pos_next;
				sat_q   <= sat_now;
				hit_q   <= hit_now;
				first_q <= first_now;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/substring_first_match.sv =====
// out_valid comes from the output register, set when the last byte of a text advances out of the input register.
// Throughput: one text byte per cycle while in_stall is low; the window compare is combinational
// logic between the input register and the result register.
// A pending result stalls input only when its final byte waits on a stalled output register.
// Reset (arst_n low) clears the pattern registers, valid flags and the match state.
`default_nettype none

// ----------------------------------------------------------------------------
// substring_first_match
// Streaming first-occurrence search of a configured pattern of up to 16 bytes.
// ----------------------------------------------------------------------------

`include "substring_first_match_assert.svh"

module substring_first_match (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [sfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [sfm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire sfm_pkg::in_item_t                   in_item,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output sfm_pkg::out_item_t                       out_item
);

	logic [sfm_pkg::CFG_DATA_W-1:0] pattern_low_q;
	logic [sfm_pkg::CFG_DATA_W-1:0] pattern_high_q;
	logic [sfm_pkg::CFG_LEN_W-1:0]  pattern_length_q;
	sfm_pkg::cfg_t                  cfg;

	sfm_pkg::in_item_t  in_s1;
	logic               in_valid_s1;
	sfm_pkg::out_item_t result;
	sfm_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic               advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				sfm_pkg::REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				sfm_pkg::REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				sfm_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[sfm_pkg::CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.pattern = {pattern_high_q, pattern_low_q};
	assign cfg.length  = pattern_length_q;

	// a non-final byte never needs the output register
	assign advance  = in_valid_s1 && (!in_s1.text_last || !out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_item;
		end
	end

	sfm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (in_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && in_s1.text_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_s1.text_last) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`SFM_ASSERT_IMP(a_stall_cause, in_stall, in_valid_s1 && in_s1.text_last && out_valid_q && out_stall)
	`SFM_ASSERT_NXT(a_last_gives_result, advance && in_s1.text_last, out_valid)
	`SFM_ASSERT_IMP(a_miss_index_zero, out_valid && !out_item.found, out_item.match_index == '0)

endmodule

`default_nettype wire
